// ----- rtl/core/simple_8bit_cpu_execute_unit_macros.svh -----
// Assertion helpers shared by the execute unit.
`ifndef SIMPLE_8BIT_CPU_EXECUTE_UNIT_MACROS_SVH
`define SIMPLE_8BIT_CPU_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication.
`define S8CPU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define S8CPU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/s8cpu_pkg.sv -----
package s8cpu_pkg;

    localparam int NUM_REGS  = 16;
    localparam int MEM_BYTES = 256;
    localparam int REG_AW    = $clog2(NUM_REGS);
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int Q_DEPTH   = 2;

    // instruction opcodes
    localparam logic [3:0] OP_LOAD  = 4'h1;
    localparam logic [3:0] OP_IMM   = 4'h2;
    localparam logic [3:0] OP_STORE = 4'h3;
    localparam logic [3:0] OP_MOVE  = 4'h4;
    localparam logic [3:0] OP_ADD   = 4'h5;
    localparam logic [3:0] OP_FADD  = 4'h6;
    localparam logic [3:0] OP_OR    = 4'h7;
    localparam logic [3:0] OP_AND   = 4'h8;
    localparam logic [3:0] OP_XOR   = 4'h9;
    localparam logic [3:0] OP_JEQ   = 4'hB;
    localparam logic [3:0] OP_HALT  = 4'hC;
    localparam logic [3:0] OP_JGT   = 4'hD;

    // classified operation kinds
    typedef logic [3:0] t_kind;
    localparam t_kind K_NOP   = 4'd0;
    localparam t_kind K_MEMWR = 4'd1;
    localparam t_kind K_LOAD  = 4'd2;
    localparam t_kind K_IMM   = 4'd3;
    localparam t_kind K_STORE = 4'd4;
    localparam t_kind K_MOVE  = 4'd5;
    localparam t_kind K_ADD   = 4'd6;
    localparam t_kind K_FADD  = 4'd7;
    localparam t_kind K_OR    = 4'd8;
    localparam t_kind K_AND   = 4'd9;
    localparam t_kind K_XOR   = 4'd10;
    localparam t_kind K_JEQ   = 4'd11;
    localparam t_kind K_JGT   = 4'd12;
    localparam t_kind K_HALT  = 4'd13;

    typedef struct packed {
        t_kind              kind;
        logic [REG_AW-1:0]  ra;     // first register read
        logic [REG_AW-1:0]  rb;     // second register read
        logic [REG_AW-1:0]  dest;
        logic [MEM_AW-1:0]  xy;
        logic [7:0]         data;
    } t_uop;

    typedef struct packed {
        logic [7:0] wval;
        logic       wreg;
        logic       jt;
        logic [7:0] jtgt;
        logic       halt;
        logic       fault;
    } t_result;

endpackage

// ----- rtl/core/s8cpu_ram.sv -----
module s8cpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/s8cpu_front.sv -----
module s8cpu_front import s8cpu_pkg::*; (
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [3:0]  i_opcode,
    input  logic [3:0]  i_reg_r,
    input  logic [7:0]  i_operand_xy,
    input  logic [7:0]  i_load_data,
    input  logic        i_q_full,
    output logic        o_push,
    output t_uop        o_uop
);

    logic [3:0] s_idx;
    logic [3:0] t_idx;

    assign s_idx   = i_operand_xy[7:4];
    assign t_idx   = i_operand_xy[3:0];
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_uop.kind = K_NOP;
        o_uop.ra   = s_idx;
        o_uop.rb   = t_idx;
        o_uop.dest = i_reg_r;
        o_uop.xy   = i_operand_xy;
        o_uop.data = i_load_data;
        if (!i_action) begin
            o_uop.kind = K_MEMWR;
        end else begin
            case (i_opcode)
                OP_LOAD:  o_uop.kind = K_LOAD;
                OP_IMM:   o_uop.kind = K_IMM;
                OP_STORE: begin
                    o_uop.kind = K_STORE;
                    o_uop.ra   = i_reg_r;
                end
                OP_MOVE: begin
                    o_uop.kind = K_MOVE;
                    o_uop.dest = t_idx;
                end
                OP_ADD:   o_uop.kind = K_ADD;
                OP_FADD:  o_uop.kind = K_FADD;
                OP_OR:    o_uop.kind = K_OR;
                OP_AND:   o_uop.kind = K_AND;
                OP_XOR:   o_uop.kind = K_XOR;
                OP_JEQ: begin
                    o_uop.kind = K_JEQ;
                    o_uop.ra   = i_reg_r;
                    o_uop.rb   = '0;
                end
                OP_JGT: begin
                    o_uop.kind = K_JGT;
                    o_uop.ra   = i_reg_r;
                    o_uop.rb   = '0;
                end
                OP_HALT:  o_uop.kind = K_HALT;
                default:  o_uop.kind = K_NOP;
            endcase
        end
    end

endmodule

// ----- rtl/core/s8cpu_queue.sv -----
module s8cpu_queue import s8cpu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_uop i_uop,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_uop o_uop
);

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_uop          r_slot [Q_DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_uop   = r_slot[r_rptr];

    always_comb begin
        n_wptr  = i_push ? bump(r_wptr) : r_wptr;
        n_rptr  = i_pop ? bump(r_rptr) : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_uop;
        end
    end

endmodule

// ----- rtl/core/s8cpu_back.sv -----
`include "simple_8bit_cpu_execute_unit_macros.svh"

module s8cpu_back import s8cpu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_uop    i_q_uop,
    output logic    o_q_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    // float add: bit 8 flags exponent overflow, bits 7..0 the encoded sum
    function automatic logic [8:0] fl_add(input logic [7:0] a, input logic [7:0] b);
        logic [10:0]       ma;
        logic [10:0]       mb;
        logic signed [12:0] sa;
        logic signed [12:0] sb;
        logic signed [12:0] sum;
        logic [11:0]       mag;
        logic [11:0]       sh;
        logic [3:0]        msb;
        logic [3:0]        ex;
        logic              sign;
        logic [8:0]        res;
        ma   = 11'(a[3:0]) << a[6:4];
        mb   = 11'(b[3:0]) << b[6:4];
        sa   = a[7] ? -$signed({2'b00, ma}) : $signed({2'b00, ma});
        sb   = b[7] ? -$signed({2'b00, mb}) : $signed({2'b00, mb});
        sum  = sa + sb;
        sign = sum[12];
        mag  = sign ? 12'(-sum) : sum[11:0];
        msb  = '0;
        for (int i = 0; i < 12; i++) begin
            if (mag[i]) begin
                msb = 4'(i);
            end
        end
        ex = msb - 4'd3;
        sh = mag >> ex;
        if (mag == '0) begin
            res = '0;
        end else if (msb < 4'd4) begin
            res = {1'b0, sign, 3'b000, mag[3:0]};
        end else if (msb > 4'd10) begin
            res = {1'b1, 8'h00};
        end else begin
            res = {1'b0, sign, ex[2:0], sh[3:0]};
        end
        return res;
    endfunction

    t_uop              r_e2;
    logic              r_e2_valid;
    logic [NUM_REGS-1:0]  r_rvld;
    logic [MEM_BYTES-1:0] r_mvld;
    logic              r_rv_a, r_rv_b, r_mv;
    logic              r_rf_fv, r_mf_fv;
    logic [REG_AW-1:0] r_rf_fa;
    logic [7:0]        r_rf_fd;
    logic [MEM_AW-1:0] r_mf_fa;
    logic [7:0]        r_mf_fd;
    t_result           r_out;
    logic              r_out_valid;

    logic       pop, commit;
    logic [7:0] rdata_a, rdata_b, mdata;
    logic [7:0] va, vb, vm;
    logic [7:0] val, mwval;
    logic       wreg, mem_we, rf_we;
    logic [8:0] fsum;
    t_result    res;

    assign commit  = r_e2_valid && (!r_out_valid || i_ready);
    assign pop     = i_q_valid && (!r_e2_valid || commit);
    assign o_q_pop = pop;
    assign rf_we   = commit && wreg;

    s8cpu_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_e2.dest),
        .i_wdata (val),
        .i_re    (pop),
        .i_raddr (i_q_uop.ra),
        .o_rdata (rdata_a)
    );

    s8cpu_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_e2.dest),
        .i_wdata (val),
        .i_re    (pop),
        .i_raddr (i_q_uop.rb),
        .o_rdata (rdata_b)
    );

    s8cpu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (commit && mem_we),
        .i_waddr (r_e2.xy),
        .i_wdata (mwval),
        .i_re    (pop),
        .i_raddr (i_q_uop.xy),
        .o_rdata (mdata)
    );

    // bypass the write that landed on the same edge as the read
    assign va = (r_rf_fv && r_rf_fa == r_e2.ra) ? r_rf_fd : (r_rv_a ? rdata_a : 8'h00);
    assign vb = (r_rf_fv && r_rf_fa == r_e2.rb) ? r_rf_fd : (r_rv_b ? rdata_b : 8'h00);
    assign vm = (r_mf_fv && r_mf_fa == r_e2.xy) ? r_mf_fd : (r_mv ? mdata : 8'h00);
    assign fsum = fl_add(va, vb);

    always_comb begin
        val    = 8'h00;
        mwval  = 8'h00;
        wreg   = 1'b0;
        mem_we = 1'b0;
        res    = '0;
        case (r_e2.kind)
            K_MEMWR: begin
                mem_we   = 1'b1;
                mwval    = r_e2.data;
                res.wval = r_e2.data;
            end
            K_LOAD: begin
                val  = vm;
                wreg = 1'b1;
            end
            K_IMM: begin
                val  = r_e2.xy;
                wreg = 1'b1;
            end
            K_STORE: begin
                mem_we   = 1'b1;
                mwval    = va;
                res.wval = va;
            end
            K_MOVE: begin
                val  = va;
                wreg = 1'b1;
            end
            K_ADD: begin
                val  = va + vb;
                wreg = 1'b1;
            end
            K_FADD: begin
                val       = fsum[7:0];
                wreg      = !fsum[8];
                res.fault = fsum[8];
            end
            K_OR: begin
                val  = va | vb;
                wreg = 1'b1;
            end
            K_AND: begin
                val  = va & vb;
                wreg = 1'b1;
            end
            K_XOR: begin
                val  = va ^ vb;
                wreg = 1'b1;
            end
            K_JEQ: begin
                if (va == vb) begin
                    res.jt   = 1'b1;
                    res.jtgt = r_e2.xy;
                end
            end
            K_JGT: begin
                if (va > vb) begin
                    res.jt   = 1'b1;
                    res.jtgt = r_e2.xy;
                end
            end
            K_HALT:  res.halt = 1'b1;
            default: res = '0;
        endcase
        if (wreg) begin
            res.wval = val;
            res.wreg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rvld      <= '0;
            r_mvld      <= '0;
            r_rf_fv     <= 1'b0;
            r_mf_fv     <= 1'b0;
            r_rv_a      <= 1'b0;
            r_rv_b      <= 1'b0;
            r_mv        <= 1'b0;
        end else begin
            if (pop) begin
                r_e2_valid <= 1'b1;
                r_rv_a     <= r_rvld[i_q_uop.ra];
                r_rv_b     <= r_rvld[i_q_uop.rb];
                r_mv       <= r_mvld[i_q_uop.xy];
                r_rf_fv    <= rf_we;
                r_mf_fv    <= commit && mem_we;
            end else if (commit) begin
                r_e2_valid <= 1'b0;
            end
            if (rf_we) begin
                r_rvld[r_e2.dest] <= 1'b1;
            end
            if (commit && mem_we) begin
                r_mvld[r_e2.xy] <= 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_e2    <= i_q_uop;
            r_rf_fa <= r_e2.dest;
            r_rf_fd <= val;
            r_mf_fa <= r_e2.xy;
            r_mf_fd <= mwval;
        end
        if (commit) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    `S8CPU_ASSERT_IMP(a_stall_holds_queue, i_clk, i_rst_n, r_e2_valid && !commit, !pop, "pop while execute stage stalled")
    `S8CPU_ASSERT_NXT(a_bypass_armed, i_clk, i_rst_n, pop && rf_we, r_rf_fv && r_e2_valid, "register bypass not armed")
    `S8CPU_ASSERT_IMP(a_fault_no_write, i_clk, i_rst_n, commit && res.fault, !rf_we && !mem_we, "float fault wrote state")
    `S8CPU_ASSERT_NXT(a_commit_shows, i_clk, i_rst_n, commit, r_out_valid, "committed result not presented")

endmodule

// ----- rtl/core/simple_8bit_cpu_execute_unit.sv -----
// Execute unit of the textbook 8-bit machine: 16 byte registers and a
// 256-byte memory, both reading as zero after reset (per-entry valid bits, so
// there is no clearing pass and the unit is ready straight out of reset).
// Each input transaction is either a memory byte write (action 0) or one
// decoded instruction (action 1), and gives exactly one result transaction.
// Sustained rate is one transaction per clock while the consumer is ready.
// A decoder classifies each transaction into a two-entry queue; the back
// end reads the register file and memory RAMs (registered read) on the
// cycle it pops the queue, then executes and writes back once the output
// register can take the result, with a one-entry bypass covering the write
// that lands on the same edge as the read. Results sit in an output register,
// so a stalled consumer backs up into the queue and then the input ready.
// Float add uses sign, excess-4 3-bit exponent and 4-bit fraction with no
// hidden bit; the sum is normalised and truncated, and exponent overflow
// flags float_fault and leaves the registers untouched.
module simple_8bit_cpu_execute_unit import s8cpu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic [3:0] i_opcode,
    input  logic [3:0] i_reg_r,
    input  logic [7:0] i_operand_xy,
    input  logic [7:0] i_load_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_written_value,
    output logic       o_wrote_register,
    output logic       o_jump_taken,
    output logic [7:0] o_jump_target,
    output logic       o_halted,
    output logic       o_float_fault
);

    // front to queue
    logic    push;
    logic    q_full;
    t_uop    push_uop;
    // queue to back end
    logic    q_valid;
    logic    q_pop;
    t_uop    q_uop;
    t_result res;

    s8cpu_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_opcode     (i_opcode),
        .i_reg_r      (i_reg_r),
        .i_operand_xy (i_operand_xy),
        .i_load_data  (i_load_data),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_uop        (push_uop)
    );

    s8cpu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_uop   (push_uop),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_uop   (q_uop)
    );

    s8cpu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_uop   (q_uop),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (res)
    );

    // result fields straight from the output register
    assign o_written_value  = res.wval;
    assign o_wrote_register = res.wreg;
    assign o_jump_taken     = res.jt;
    assign o_jump_target    = res.jtgt;
    assign o_halted         = res.halt;
    assign o_float_fault    = res.fault;

endmodule

// ----- tb/sv/tb_simple_8bit_cpu_execute_unit.sv -----
module tb_simple_8bit_cpu_execute_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import s8cpu_pkg::*;

    // Action codes carried on i_action
    localparam logic ACT_MEMWR = 1'b0;
    localparam logic ACT_EXEC  = 1'b1;

    // Opcodes with no instruction behind them: the unit must leave all state alone
    localparam logic [3:0] OP_RSV0 = 4'h0;
    localparam logic [3:0] OP_RSVA = 4'hA;

    // Whether a table row carries a hand-written expectation or leans on the predictor
    localparam logic PREDICT = 1'b0;
    localparam logic TYPED   = 1'b1;

    localparam t_result BY_MODEL = '0;

    localparam int RAND_ITEMS = 1900;
    localparam int IDLE_PCT   = 13;

    localparam logic [3:0] EXEC_OPS [12] = '{OP_LOAD, OP_IMM, OP_STORE, OP_MOVE,
                                             OP_ADD, OP_FADD, OP_OR, OP_AND,
                                             OP_XOR, OP_JEQ, OP_HALT, OP_JGT};

    // Bytes that collide often: equal registers for the jumps, large floats of
    // either sign for exponent overflow, negative zero, and the extremes
    localparam logic [7:0] VALUE_POOL [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hF8, 8'hFF};

    typedef struct {
        logic       act;
        logic [3:0] op;
        logic [3:0] rr;
        logic [7:0] xy;
        logic [7:0] data;
        logic       fixed;
        t_result    want;
    } t_step;

    // Every input known from time zero
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       i_action     = ACT_MEMWR;
    logic [3:0] i_opcode     = OP_RSV0;
    logic [3:0] i_reg_r      = 4'h0;
    logic [7:0] i_operand_xy = 8'h00;
    logic [7:0] i_load_data  = 8'h00;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_written_value;
    logic       o_wrote_register;
    logic       o_jump_taken;
    logic [7:0] o_jump_target;
    logic       o_halted;
    logic       o_float_fault;

    // Side information travelling with the transaction currently offered
    logic    cur_fixed = PREDICT;
    t_result cur_want  = '0;

    // Shadow copy of the architectural state
    logic [7:0] gpr_shadow [NUM_REGS]  = '{default: 8'h00};
    logic [7:0] mem_shadow [MEM_BYTES] = '{default: 8'h00};

    t_result pending_results [$];
    t_step   directed [$];
    int      miss_count  = 0;
    logic    quiet_phase = 1'b0;

    simple_8bit_cpu_execute_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_opcode         (i_opcode),
        .i_reg_r          (i_reg_r),
        .i_operand_xy     (i_operand_xy),
        .i_load_data      (i_load_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_written_value  (o_written_value),
        .o_wrote_register (o_wrote_register),
        .o_jump_taken     (o_jump_taken),
        .o_jump_target    (o_jump_target),
        .o_halted         (o_halted),
        .o_float_fault    (o_float_fault)
    );

    always #6 i_clk = ~i_clk;

    // Signed magnitude of a packed float in units of 2^-8: fraction shifted by
    // the raw exponent field, no hidden bit
    function automatic int fp_value(input logic [7:0] b);
        int mag;
        mag = int'(b[3:0]) << b[6:4];
        return b[7] ? -mag : mag;
    endfunction

    // Executes one transaction against the shadow state and returns its result
    function automatic t_result exec_instruction(input logic act, input logic [3:0] op,
                                                 input logic [3:0] rr, input logic [7:0] xy,
                                                 input logic [7:0] data);
        t_result    res;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] val;
        logic       wr;
        logic       neg;
        logic [3:0] dst;
        int         sum;
        int         mag;
        int         sh;
        int         frac;
        res = '0;
        val = 8'h00;
        wr  = 1'b0;
        dst = rr;
        a   = gpr_shadow[xy[7:4]];
        b   = gpr_shadow[xy[3:0]];
        if (act == ACT_MEMWR) begin
            mem_shadow[xy] = data;
            res.wval = data;
            return res;
        end
        case (op)
            OP_LOAD: begin
                val = mem_shadow[xy];
                wr  = 1'b1;
            end
            OP_IMM: begin
                val = xy;
                wr  = 1'b1;
            end
            OP_STORE: begin
                mem_shadow[xy] = gpr_shadow[rr];
                res.wval = gpr_shadow[rr];
            end
            OP_MOVE: begin
                // S into T, reg_r plays no part
                val = a;
                dst = xy[3:0];
                wr  = 1'b1;
            end
            OP_ADD: begin
                val = a + b;
                wr  = 1'b1;
            end
            OP_FADD: begin
                // Exact sum, then shift right until the fraction fits in four
                // bits; dropped bits truncate. Small sums keep exponent 0 and a
                // zero sum packs to 0x00 with the sign clear.
                sum = fp_value(a) + fp_value(b);
                neg = (sum < 0);
                mag = neg ? -sum : sum;
                sh  = 0;
                while ((mag >> sh) > 15)
                    sh++;
                if (sh > 7) begin
                    res.fault = 1'b1;
                end else begin
                    frac = mag >> sh;
                    val  = {neg, sh[2:0], frac[3:0]};
                    wr   = 1'b1;
                end
            end
            OP_OR: begin
                val = a | b;
                wr  = 1'b1;
            end
            OP_AND: begin
                val = a & b;
                wr  = 1'b1;
            end
            OP_XOR: begin
                val = a ^ b;
                wr  = 1'b1;
            end
            OP_JEQ: begin
                if (gpr_shadow[rr] == gpr_shadow[0]) begin
                    res.jt   = 1'b1;
                    res.jtgt = xy;
                end
            end
            OP_HALT: res.halt = 1'b1;
            OP_JGT: begin
                if (gpr_shadow[rr] > gpr_shadow[0]) begin
                    res.jt   = 1'b1;
                    res.jtgt = xy;
                end
            end
            default: ;
        endcase
        if (wr) begin
            gpr_shadow[dst] = val;
            res.wval = val;
            res.wreg = 1'b1;
        end
        return res;
    endfunction

    task automatic add_step(input logic act, input logic [3:0] op, input logic [3:0] rr,
                            input logic [7:0] xy, input logic [7:0] data,
                            input logic fixed, input t_result want);
        t_step s;
        s.act   = act;
        s.op    = op;
        s.rr    = rr;
        s.xy    = xy;
        s.data  = data;
        s.fixed = fixed;
        s.want  = want;
        directed.push_back(s);
    endtask

    // Offers one transaction and returns on the edge at which it is taken.
    // Idle cycles go in front of it now and then; valid stays up once raised.
    task automatic send(input t_step s);
        while (!quiet_phase && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= s.act;
        i_opcode     <= s.op;
        i_reg_r      <= s.rr;
        i_operand_xy <= s.xy;
        i_load_data  <= s.data;
        cur_fixed    <= s.fixed;
        cur_want     <= s.want;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // Result side back-pressure, switched off during the quiet phase
    always @(posedge i_clk) begin
        i_ready <= quiet_phase || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Scoreboard. Everything is sampled at the edge, before any of this
    // edge's updates land, so the input push comes ahead of the result pop and
    // a same-cycle result would still find its expectation.
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                want = exec_instruction(i_action, i_opcode, i_reg_r, i_operand_xy,
                                        i_load_data);
                if (cur_fixed == TYPED)
                    want = cur_want;
                pending_results.push_back(want);
            end
            if (o_valid && i_ready) begin
                got = {o_written_value, o_wrote_register, o_jump_taken, o_jump_target,
                       o_halted, o_float_fault};
                if (pending_results.size() == 0) begin
                    if (miss_count < 10)
                        $display("%0t: result transaction with nothing outstanding", $time);
                    miss_count++;
                end else begin
                    want = pending_results.pop_front();
                    // !== so that X or Z on any field counts as a mismatch
                    if (got.wval !== want.wval || got.wreg !== want.wreg ||
                        got.jt !== want.jt || got.jtgt !== want.jtgt ||
                        got.halt !== want.halt || got.fault !== want.fault) begin
                        if (miss_count < 10)
                            $display("%0t: mismatch", $time,
                                     " exp wval=%h wreg=%b jt=%b tgt=%h halt=%b flt=%b",
                                     want.wval, want.wreg, want.jt, want.jtgt, want.halt,
                                     want.fault,
                                     " | got wval=%h wreg=%b jt=%b tgt=%h halt=%b flt=%b",
                                     got.wval, got.wreg, got.jt, got.jtgt,
                                     got.halt, got.fault);
                        miss_count++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_step s;
        int    n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Rows straight after reset, the extremes and the
        // overflow fault carry their result; the rest go through the predictor.
        // Fresh state: memory reads zero, every register equals R0
        add_step(ACT_EXEC,  OP_LOAD,  4'h1, 8'h00, 8'h00, TYPED,
                 '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
        add_step(ACT_EXEC,  OP_JEQ,   4'h5, 8'h44, 8'h00, TYPED,
                 '{8'h00, 1'b0, 1'b1, 8'h44, 1'b0, 1'b0});
        add_step(ACT_EXEC,  OP_JGT,   4'h5, 8'h55, 8'h00, TYPED, '0);
        add_step(ACT_EXEC,  OP_HALT,  4'h0, 8'h00, 8'h00, TYPED,
                 '{8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0});
        // Unused opcodes do nothing at all
        add_step(ACT_EXEC,  OP_RSV0,  4'hF, 8'hFF, 8'hFF, TYPED, '0);
        add_step(ACT_EXEC,  OP_RSVA,  4'h0, 8'h00, 8'h00, TYPED, '0);
        // Memory writes ignore opcode and reg_r
        add_step(ACT_MEMWR, OP_HALT,  4'hF, 8'hFF, 8'hFF, TYPED,
                 '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
        add_step(ACT_MEMWR, OP_RSV0,  4'h0, 8'h00, 8'hA5, TYPED,
                 '{8'hA5, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
        add_step(ACT_EXEC,  OP_LOAD,  4'h2, 8'hFF, 8'h00, TYPED,
                 '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
        add_step(ACT_EXEC,  OP_IMM,   4'hF, 8'h80, 8'h00, TYPED,
                 '{8'h80, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
        add_step(ACT_EXEC,  OP_IMM,   4'h1, 8'h7F, 8'h00, TYPED,
                 '{8'h7F, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
        add_step(ACT_EXEC,  OP_ADD,   4'h3, 8'h21, 8'h00, PREDICT, BY_MODEL);
        // Largest positive float doubled: exponent overflow, R4 untouched
        add_step(ACT_EXEC,  OP_FADD,  4'h4, 8'h11, 8'h00, TYPED,
                 '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1});
        // Negative zero plus zero packs to plain zero
        add_step(ACT_EXEC,  OP_FADD,  4'h5, 8'hF0, 8'h00, PREDICT, BY_MODEL);
        add_step(ACT_EXEC,  OP_IMM,   4'h6, 8'h03, 8'h00, PREDICT, BY_MODEL);
        // Sum too small to normalise keeps exponent zero
        add_step(ACT_EXEC,  OP_FADD,  4'h7, 8'h66, 8'h00, PREDICT, BY_MODEL);
        add_step(ACT_EXEC,  OP_IMM,   4'h8, 8'h83, 8'h00, PREDICT, BY_MODEL);
        // Equal magnitudes of opposite sign cancel
        add_step(ACT_EXEC,  OP_FADD,  4'h9, 8'h68, 8'h00, PREDICT, BY_MODEL);
        // Move R2 to R10; reg_r must not matter
        add_step(ACT_EXEC,  OP_MOVE,  4'h3, 8'h2A, 8'h00, PREDICT, BY_MODEL);
        add_step(ACT_EXEC,  OP_STORE, 4'hA, 8'h10, 8'h00, PREDICT, BY_MODEL);
        add_step(ACT_EXEC,  OP_OR,    4'hB, 8'h1F, 8'h00, PREDICT, BY_MODEL);
        add_step(ACT_EXEC,  OP_AND,   4'hC, 8'h2F, 8'h00, PREDICT, BY_MODEL);
        add_step(ACT_EXEC,  OP_XOR,   4'hD, 8'h21, 8'h00, PREDICT, BY_MODEL);
        add_step(ACT_EXEC,  OP_JGT,   4'h2, 8'h9C, 8'h00, PREDICT, BY_MODEL);
        add_step(ACT_EXEC,  OP_JEQ,   4'h2, 8'h3D, 8'h00, PREDICT, BY_MODEL);

        foreach (directed[i])
            send(directed[i]);

        // Random traffic: mostly real instructions, a tenth of any opcode at
        // all, memory writes in between. Addresses and immediates are often
        // steered to a small set so loads find written bytes and jumps fire.
        for (n = 0; n < RAND_ITEMS; n++) begin
            quiet_phase = (n >= 800 && n < 1100);
            s.act   = ($urandom_range(0, 99) < 15) ? ACT_MEMWR : ACT_EXEC;
            s.op    = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                  : EXEC_OPS[$urandom_range(0, 11)];
            s.rr    = 4'($urandom_range(0, 15));
            s.xy    = 8'($urandom_range(0, 255));
            s.data  = 8'($urandom_range(0, 255));
            s.fixed = PREDICT;
            s.want  = BY_MODEL;
            if ($urandom_range(0, 2) == 0)
                s.data = VALUE_POOL[$urandom_range(0, 5)];
            if (s.act == ACT_MEMWR || s.op == OP_LOAD || s.op == OP_STORE) begin
                if ($urandom_range(0, 1) == 0)
                    s.xy = 8'($urandom_range(0, 15));
            end else if (s.op == OP_IMM && $urandom_range(0, 2) != 0) begin
                s.xy = VALUE_POOL[$urandom_range(0, 5)];
            end
            send(s);
        end
        i_valid     <= 1'b0;
        quiet_phase  = 1'b0;

        // Drain, then keep watching the outputs to catch anything spurious
        for (n = 0; n < 2000 && pending_results.size() != 0; n++)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d result transactions never arrived", pending_results.size());
            miss_count += pending_results.size();
        end
        if (miss_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog, far beyond any correct run
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- simple_8bit_cpu_execute_unit.f -----
+incdir+rtl/core
rtl/core/s8cpu_pkg.sv
rtl/core/s8cpu_ram.sv
rtl/core/s8cpu_front.sv
rtl/core/s8cpu_queue.sv
rtl/core/s8cpu_back.sv
rtl/core/simple_8bit_cpu_execute_unit.sv
tb/sv/tb_simple_8bit_cpu_execute_unit.sv
